// ===== design/mtp_pkg.sv =====
// shared constants, state type and word functions for the mt19937 generator
package mtp_pkg;

  // generator geometry
  localparam int STATE_WORDS = 624;
  localparam int MID_OFFSET  = 397;
  localparam int IDX_W       = $clog2(STATE_WORDS);

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [31:0]      word_t;

  localparam idx_t LAST_IDX     = IDX_W'(STATE_WORDS - 1);
  localparam idx_t MID_IDX      = IDX_W'(MID_OFFSET);
  localparam idx_t MID_WRAP_IDX = IDX_W'(STATE_WORDS - MID_OFFSET);

  // algorithm constants
  localparam word_t MATRIX_A     = 32'h9908_b0df;
  localparam word_t UPPER_MASK   = 32'h8000_0000;
  localparam word_t LOWER_MASK   = 32'h7fff_ffff;
  localparam word_t TEMPER_B     = 32'h9d2c_5680;
  localparam word_t TEMPER_C     = 32'hefc6_0000;
  localparam word_t SEED_MULT    = 32'd1812433253;
  localparam word_t DEFAULT_SEED = 32'h0000_1571;

  // command codes
  localparam logic OP_DRAW = 1'b0;
  localparam logic OP_SEED = 1'b1;

  // sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_SEED_WR,
    S_SEED_MUL,
    S_DRAW
  } mtp_state_t;

  // one step of the twist recurrence
  function automatic word_t twist_word(word_t hi_src, word_t lo_src, word_t mid_src);
    word_t y;
    word_t v;
    y = (hi_src & UPPER_MASK) | (lo_src & LOWER_MASK);
    v = mid_src ^ (y >> 1);
    if (y[0]) begin
      v = v ^ MATRIX_A;
    end
    return v;
  endfunction

  // output tempering
  function automatic word_t temper(word_t x);
    word_t y;
    y = x;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

  // pre-multiply mixing of the seed recurrence
  function automatic word_t seed_mix(word_t x);
    return x ^ (x >> 30);
  endfunction

endpackage

// ===== design/mtp_ram.sv =====
// generic ram: one write port, two registered read ports
module mtp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 624
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_a_addr,
  output logic [WIDTH-1:0]         rd_a_data,
  input  logic [$clog2(DEPTH)-1:0] rd_b_addr,
  output logic [WIDTH-1:0]         rd_b_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_a_data_r;
  logic [WIDTH-1:0] rd_b_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // registered reads
  always_ff @(posedge clk) begin
    rd_a_data_r <= mem_r[rd_a_addr];
    rd_b_data_r <= mem_r[rd_b_addr];
  end

  assign rd_a_data = rd_a_data_r;
  assign rd_b_data = rd_b_data_r;

endmodule

// ===== design/mersenne_twister_prng_unit.sv =====
// mt19937 generator top level: command sequencer, state memory and tempering
//
// A draw (opcode 0) is taken while busy is low. Once seeded, the cycle after the
// transfer is the draw cycle, and in the cycle after that its tempered word is on
// out_random_word with out_valid high for one cycle. Draws may follow one another
// every cycle, one word per cycle, while no seed fill holds busy high, since
// each draw twists just its own state word in place (two memory reads per draw
// on the two read ports, one write back). A seed (opcode 1) fills the 624-word
// memory through the multiply-and-add recurrence, each word after the first
// through a multiply state and then an add-and-write state: busy is high until
// the last word is written and no result is given. A draw issued before any seed
// first seeds with 5489, with busy high in the same way, and then gives its word.
// The receiver cannot stall, so every strobed word must be captured when shown.
module mersenne_twister_prng_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_opcode,
  input  logic [31:0] in_seed_value,
  output logic        out_valid,
  output logic [31:0] out_random_word
);

  mtp_pkg::mtp_state_t state_r, state_nxt;
  mtp_pkg::idx_t       ptr_r, ptr_nxt;
  mtp_pkg::idx_t       k_r, k_nxt;
  logic                seeded_r, seeded_nxt;
  logic                pend_r, pend_nxt;
  logic                out_valid_r, out_valid_nxt;
  mtp_pkg::word_t      prev_r, prev_nxt;
  mtp_pkg::word_t      prod_r, prod_nxt;
  mtp_pkg::word_t      cur_r, cur_nxt;
  mtp_pkg::word_t      out_word_r, out_word_nxt;

  logic                accept;
  logic                need_seed;
  logic                wr_en;
  mtp_pkg::idx_t       wr_addr;
  mtp_pkg::word_t      wr_data;
  mtp_pkg::idx_t       rd_a_addr;
  mtp_pkg::idx_t       rd_b_addr;
  mtp_pkg::word_t      rd_a_data;
  mtp_pkg::word_t      rd_b_data;
  mtp_pkg::word_t      twisted;
  mtp_pkg::word_t      seed_word;

  // state memory
  mtp_ram #(
    .WIDTH (32),
    .DEPTH (mtp_pkg::STATE_WORDS)
  ) u_ram (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_a_addr (rd_a_addr),
    .rd_a_data (rd_a_data),
    .rd_b_addr (rd_b_addr),
    .rd_b_data (rd_b_data)
  );

  // transfer and seeding decisions
  assign accept    = start && !busy;
  assign need_seed = (in_opcode == mtp_pkg::OP_SEED) || !seeded_r;

  // twisted word for the current draw and next word of the seed recurrence
  assign twisted   = mtp_pkg::twist_word(cur_r, rd_a_data, rd_b_data);
  assign seed_word = (k_r == '0) ? prev_r : prod_r + 32'(k_r);

  // read addresses follow the pointer of the next draw
  always_comb begin
    rd_a_addr = (ptr_nxt == mtp_pkg::LAST_IDX) ? '0 : ptr_nxt + 1'b1;
    if (ptr_nxt >= mtp_pkg::MID_WRAP_IDX) begin
      rd_b_addr = ptr_nxt - mtp_pkg::MID_WRAP_IDX;
    end else begin
      rd_b_addr = ptr_nxt + mtp_pkg::MID_IDX;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mtp_pkg::S_IDLE: begin
        if (accept) begin
          state_nxt = need_seed ? mtp_pkg::S_SEED_WR : mtp_pkg::S_DRAW;
        end
      end
      mtp_pkg::S_SEED_WR: begin
        if (k_r == mtp_pkg::LAST_IDX) begin
          state_nxt = pend_r ? mtp_pkg::S_DRAW : mtp_pkg::S_IDLE;
        end else begin
          state_nxt = mtp_pkg::S_SEED_MUL;
        end
      end
      mtp_pkg::S_SEED_MUL: begin
        state_nxt = mtp_pkg::S_SEED_WR;
      end
      mtp_pkg::S_DRAW: begin
        if (accept) begin
          state_nxt = need_seed ? mtp_pkg::S_SEED_WR : mtp_pkg::S_DRAW;
        end else begin
          state_nxt = mtp_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = mtp_pkg::S_IDLE;
      end
    endcase
  end

  // outputs and datapath
  always_comb begin
    busy          = 1'b1;
    wr_en         = 1'b0;
    wr_addr       = ptr_r;
    wr_data       = twisted;
    ptr_nxt       = ptr_r;
    k_nxt         = k_r;
    seeded_nxt    = seeded_r;
    pend_nxt      = pend_r;
    prev_nxt      = prev_r;
    prod_nxt      = prod_r;
    cur_nxt       = cur_r;
    out_valid_nxt = 1'b0;
    out_word_nxt  = out_word_r;
    case (state_r)
      mtp_pkg::S_IDLE: begin
        busy = 1'b0;
      end
      mtp_pkg::S_SEED_WR: begin
        wr_en    = 1'b1;
        wr_addr  = k_r;
        wr_data  = seed_word;
        prev_nxt = seed_word;
        if (k_r == mtp_pkg::LAST_IDX) begin
          ptr_nxt    = '0;
          seeded_nxt = 1'b1;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      mtp_pkg::S_SEED_MUL: begin
        prod_nxt = 32'(mtp_pkg::seed_mix(prev_r) * mtp_pkg::SEED_MULT);
      end
      mtp_pkg::S_DRAW: begin
        busy          = 1'b0;
        wr_en         = 1'b1;
        wr_addr       = ptr_r;
        wr_data       = twisted;
        cur_nxt       = rd_a_data;
        out_valid_nxt = 1'b1;
        out_word_nxt  = mtp_pkg::temper(twisted);
        ptr_nxt       = (ptr_r == mtp_pkg::LAST_IDX) ? '0 : ptr_r + 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
    // a seed transfer, or a draw with no seed yet, restarts the fill
    if (accept && need_seed) begin
      prev_nxt = (in_opcode == mtp_pkg::OP_SEED) ? in_seed_value : mtp_pkg::DEFAULT_SEED;
      cur_nxt  = (in_opcode == mtp_pkg::OP_SEED) ? in_seed_value : mtp_pkg::DEFAULT_SEED;
      k_nxt    = '0;
      pend_nxt = (in_opcode == mtp_pkg::OP_DRAW);
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mtp_pkg::S_IDLE;
      ptr_r       <= '0;
      k_r         <= '0;
      seeded_r    <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ptr_r       <= ptr_nxt;
      k_r         <= k_nxt;
      seeded_r    <= seeded_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    prev_r     <= prev_nxt;
    prod_r     <= prod_nxt;
    cur_r      <= cur_nxt;
    out_word_r <= out_word_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_random_word = out_word_r;

  // checks
  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    ptr_r <= mtp_pkg::LAST_IDX)
    else $error("draw pointer beyond last state word");

  a_wr_range: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> wr_addr <= mtp_pkg::LAST_IDX)
    else $error("state memory write beyond last word");

  a_draw_seeded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mtp_pkg::S_DRAW) |-> seeded_r)
    else $error("draw issued on an unseeded state");

  a_strobe_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == mtp_pkg::S_DRAW))
    else $error("result strobe without a preceding draw cycle");

  a_seeded_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    seeded_r |=> seeded_r)
    else $error("seeded flag dropped");

endmodule
